[sv/hsvk_pkg.sv]
// shared types, constants and register codes for the hsv color key mask
package hsvk_pkg;

  // window geometry
  localparam int    HALF_WINDOW = 20;
  localparam int    MAX_DIM     = 4096;
  localparam longint WIN_SIZE   = 64'(4 * HALF_WINDOW * HALF_WINDOW);
  localparam longint SUM_CAP    = WIN_SIZE * 255;

  // widths
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 13;
  localparam int COUNT_W   = $clog2(MAX_DIM);
  localparam int SPAN_W    = DIM_W + 1;
  localparam int SUM_W     = $clog2(SUM_CAP + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = DIM_W;

  // floor(x / WIN_SIZE) as (x * DIV_MULT) >> DIV_SHIFT, exact for x <= SUM_CAP
  localparam int     DIV_SHIFT  = $clog2(SUM_CAP * WIN_SIZE);
  localparam longint DIV_MULT   = ((64'd1 << DIV_SHIFT) + WIN_SIZE - 1) / WIN_SIZE;
  localparam int     DIV_MULT_W = $clog2(DIV_MULT + 1);
  localparam int     PROD_W     = SUM_W + DIV_MULT_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_TOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_TOL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_TOL      = 3'd4;

  // register reset values
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [PIX_W-1:0] RST_HUE_TOL      = 8'd10;
  localparam logic [PIX_W-1:0] RST_SAT_TOL      = 8'd70;
  localparam logic [PIX_W-1:0] RST_VAL_TOL      = 8'd144;

  // action codes
  localparam logic ACT_SAMPLE   = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic action;
    pix_t pix_hue;
    pix_t pix_sat;
    pix_t pix_val;
    logic frame_end;
  } hsvk_in_t;

  typedef struct packed {
    logic is_table;
    logic mask_last;
  } hsvk_out_t;

  typedef struct packed {
    pix_t hue;
    pix_t sat;
    pix_t val;
  } hsvk_mean_t;

endpackage

[sv/hsvk_sampler.sv]
// window position tracking, saturating window sums and reference mean latch
module hsvk_sampler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sample_en,
  input  hsvk_pkg::hsvk_in_t pix,
  input  hsvk_pkg::dim_t    frame_width,
  input  hsvk_pkg::dim_t    frame_height,
  output hsvk_pkg::hsvk_mean_t means
);
  import hsvk_pkg::*;

  logic [COUNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  sum_t sum_hue_r, sum_hue_nxt, sum_sat_r, sum_sat_nxt, sum_val_r, sum_val_nxt;
  sum_t fin_hue_r, fin_sat_r, fin_val_r;
  logic div_go_r;
  hsvk_mean_t mean_r, mean_nxt;

  dim_t w_eff, h_eff;
  logic [SPAN_W-1:0] col_ext, row_ext, col_inc, row_inc;
  logic [SPAN_W-1:0] w_centre, h_centre;
  logic in_window;
  sum_t acc_hue, acc_sat, acc_val;
  logic [PROD_W-1:0] prod_hue, prod_sat, prod_val;

  function automatic sum_t add_sat(sum_t s, pix_t v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(v);
    return (t > (SUM_W + 1)'(SUM_CAP)) ? SUM_W'(SUM_CAP) : t[SUM_W-1:0];
  endfunction

  // zero counts as one, anything above the largest frame counts as that
  always_comb begin
    w_eff = (frame_width == '0) ? DIM_W'(1) :
            (frame_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width;
    h_eff = (frame_height == '0) ? DIM_W'(1) :
            (frame_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height;
  end

  always_comb begin
    col_ext   = SPAN_W'(col_r);
    row_ext   = SPAN_W'(row_r);
    col_inc   = col_ext + SPAN_W'(1);
    row_inc   = row_ext + SPAN_W'(1);
    w_centre  = SPAN_W'(w_eff >> 1);
    h_centre  = SPAN_W'(h_eff >> 1);
    in_window = (col_ext + SPAN_W'(HALF_WINDOW) >= w_centre) &&
                (col_ext < w_centre + SPAN_W'(HALF_WINDOW)) &&
                (row_ext + SPAN_W'(HALF_WINDOW) >= h_centre) &&
                (row_ext < h_centre + SPAN_W'(HALF_WINDOW));
  end

  always_comb begin
    acc_hue = in_window ? add_sat(sum_hue_r, pix.pix_hue) : sum_hue_r;
    acc_sat = in_window ? add_sat(sum_sat_r, pix.pix_sat) : sum_sat_r;
    acc_val = in_window ? add_sat(sum_val_r, pix.pix_val) : sum_val_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    sum_hue_nxt = sum_hue_r;
    sum_sat_nxt = sum_sat_r;
    sum_val_nxt = sum_val_r;
    if (sample_en) begin
      if (pix.frame_end) begin
        col_nxt     = '0;
        row_nxt     = '0;
        sum_hue_nxt = '0;
        sum_sat_nxt = '0;
        sum_val_nxt = '0;
      end else begin
        sum_hue_nxt = acc_hue;
        sum_sat_nxt = acc_sat;
        sum_val_nxt = acc_val;
        if (col_inc >= SPAN_W'(w_eff)) begin
          col_nxt = '0;
          row_nxt = (row_inc >= SPAN_W'(h_eff)) ? '0 : row_inc[COUNT_W-1:0];
        end else begin
          col_nxt = col_inc[COUNT_W-1:0];
        end
      end
    end
  end

  // divide by the window size via reciprocal multiply; means load from the frame end sums when div_go_r is set
  always_comb begin
    prod_hue = PROD_W'(fin_hue_r) * PROD_W'(DIV_MULT);
    prod_sat = PROD_W'(fin_sat_r) * PROD_W'(DIV_MULT);
    prod_val = PROD_W'(fin_val_r) * PROD_W'(DIV_MULT);
    mean_nxt = mean_r;
    if (div_go_r) begin
      mean_nxt.hue = prod_hue[DIV_SHIFT +: PIX_W];
      mean_nxt.sat = prod_sat[DIV_SHIFT +: PIX_W];
      mean_nxt.val = prod_val[DIV_SHIFT +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      sum_hue_r <= '0;
      sum_sat_r <= '0;
      sum_val_r <= '0;
      div_go_r  <= 1'b0;
      mean_r    <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      sum_hue_r <= sum_hue_nxt;
      sum_sat_r <= sum_sat_nxt;
      sum_val_r <= sum_val_nxt;
      div_go_r  <= sample_en && pix.frame_end;
      mean_r    <= mean_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_en && pix.frame_end) begin
      fin_hue_r <= acc_hue;
      fin_sat_r <= acc_sat;
      fin_val_r <= acc_val;
    end
  end

  assign means = mean_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_en && pix.frame_end) |=> (col_r == '0 && row_r == '0 &&
      sum_hue_r == '0 && sum_sat_r == '0 && sum_val_r == '0))
    else $error("frame end did not clear sums and counters");

  a_sum_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_hue_r <= SUM_W'(SUM_CAP)) && (sum_sat_r <= SUM_W'(SUM_CAP)) &&
    (sum_val_r <= SUM_W'(SUM_CAP)))
    else $error("window sum above saturation cap");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !sample_en |=> ($stable(sum_hue_r) && $stable(col_r) && $stable(row_r)))
    else $error("sampling state moved without a sampling request");

  a_mean_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    !div_go_r |=> $stable(mean_r))
    else $error("means changed outside the frame end update");

endmodule

[sv/adaptive_hsv_color_key_mask.sv]
// top level: config registers, request pipeline and per-pixel color key compare
// a classify request passes the input register and stage two, then its result strobe is registered
// throughput: one request per clock, busy only while reset is held; no result for sampling requests
// means latch through div_go_r and mean_r after the sampling frame end request leaves the input register,
// in time for a classify request that follows it directly
// reset (synchronous, active low): registers to defaults, counters, sums and means to zero
module adaptive_hsv_color_key_mask (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  hsvk_pkg::hsvk_in_t               in_data,
  output logic                             out_strobe,
  output hsvk_pkg::hsvk_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [hsvk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsvk_pkg::CFG_W-1:0]       cfg_data
);
  import hsvk_pkg::*;

  dim_t frame_width_r, frame_height_r;
  pix_t hue_tol_r, sat_tol_r, val_tol_r;

  logic      s1_valid_r, s2_valid_r, out_strobe_r;
  hsvk_in_t  s1_data_r, s2_data_r;
  hsvk_out_t out_data_r, out_data_nxt;
  hsvk_mean_t means;
  logic      accept, sample_en;
  pix_t      d_hue, d_sat, d_val;

  assign busy      = ~rst_n;
  assign accept    = start && !busy;
  assign sample_en = s1_valid_r && (s1_data_r.action == ACT_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      hue_tol_r      <= RST_HUE_TOL;
      sat_tol_r      <= RST_SAT_TOL;
      val_tol_r      <= RST_VAL_TOL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
        REG_HUE_TOL:      hue_tol_r      <= cfg_data[PIX_W-1:0];
        REG_SAT_TOL:      sat_tol_r      <= cfg_data[PIX_W-1:0];
        REG_VAL_TOL:      val_tol_r      <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  hsvk_sampler u_sampler (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_en    (sample_en),
    .pix          (s1_data_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .means        (means)
  );

  // stage two compares against means that already include any earlier frame end
  always_comb begin
    d_hue = (s2_data_r.pix_hue >= means.hue) ? s2_data_r.pix_hue - means.hue
                                             : means.hue - s2_data_r.pix_hue;
    d_sat = (s2_data_r.pix_sat >= means.sat) ? s2_data_r.pix_sat - means.sat
                                             : means.sat - s2_data_r.pix_sat;
    d_val = (s2_data_r.pix_val >= means.val) ? s2_data_r.pix_val - means.val
                                             : means.val - s2_data_r.pix_val;
    out_data_nxt.is_table  = (d_hue <= hue_tol_r) && (d_sat <= sat_tol_r) &&
                             (d_val <= val_tol_r);
    out_data_nxt.mask_last = s2_data_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_valid_r   <= accept;
      s2_valid_r   <= s1_valid_r;
      out_strobe_r <= s2_valid_r && (s2_data_r.action == ACT_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= in_data;
    s2_data_r  <= s1_data_r;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(s1_valid_r, 2) && $past(s2_data_r.action) == ACT_CLASSIFY))
    else $error("result strobe without a classify request");

  a_sample_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_data_r.action == ACT_SAMPLE) |=> !out_strobe_r)
    else $error("sampling request produced a result");

  a_classify_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_data_r.action == ACT_CLASSIFY) |=> out_strobe_r)
    else $error("classify request lost");

endmodule
